// ===== src/csg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the clipped spiral scan generator.
package csg_pkg;

    localparam int unsigned COORD_W = 4;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned LEG_W   = 5;
    localparam int unsigned CNT_W   = 7;
    localparam int unsigned CELL_W  = 7;
    localparam int unsigned VIDX_W  = 6;

    localparam logic [COORD_W-1:0] MAX_SIDE   = 4'd8;
    localparam logic [COORD_W-1:0] SIDE_RESET = 4'd8;

    typedef enum logic [1:0] {
        HEAD_LEFT  = 2'd0,
        HEAD_UP    = 2'd1,
        HEAD_RIGHT = 2'd2,
        HEAD_DOWN  = 2'd3
    } t_heading;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic walk;
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_status;

    // Limits a 1-based value to the range 1..hi.
    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic [COORD_W-1:0] v,
        input logic [COORD_W-1:0] hi
    );
        logic [COORD_W-1:0] r;
        if (v == '0) begin
            r = COORD_W'(1);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] step_row(input t_heading h);
        logic signed [POS_W-1:0] r;
        unique case (h)
            HEAD_UP:   r = -POS_W'(signed'(1));
            HEAD_DOWN: r = POS_W'(signed'(1));
            default:   r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] step_col(input t_heading h);
        logic signed [POS_W-1:0] r;
        unique case (h)
            HEAD_LEFT:  r = -POS_W'(signed'(1));
            HEAD_RIGHT: r = POS_W'(signed'(1));
            default:    r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/csg_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine that starts a spiral walk and ends it after the last cell.
module csg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start_valid,
    input  csg_pkg::t_status i_status,
    output logic             o_start_ready,
    output csg_pkg::t_cmd    o_cmd
);
    import csg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start_valid) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_status.done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_start_ready = 1'b0;
        o_cmd         = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_start_ready = 1'b1;
                o_cmd.load    = i_start_valid;
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

// ===== src/csg_datapath.sv =====
`timescale 1ns / 1ps
// Datapath holding the spiral position, leg counters and the output register.
module csg_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  csg_pkg::t_cmd                 i_cmd,
    input  logic [csg_pkg::COORD_W-1:0]   i_side,
    input  logic [csg_pkg::COORD_W-1:0]   i_start_row,
    input  logic [csg_pkg::COORD_W-1:0]   i_start_col,
    input  logic                          i_out_ready,
    output csg_pkg::t_status              o_status,
    output logic                          o_out_valid,
    output logic [csg_pkg::CELL_W-1:0]    o_cell_number,
    output logic [csg_pkg::VIDX_W-1:0]    o_visit_index,
    output logic                          o_last
);
    import csg_pkg::*;

    logic signed [POS_W-1:0] r_row;
    logic signed [POS_W-1:0] r_col;
    t_heading                r_heading;
    logic [LEG_W-1:0]        r_leg_len;
    logic [LEG_W-1:0]        r_leg_step;
    logic [CNT_W-1:0]        r_count;
    logic [COORD_W-1:0]      r_side;
    logic [CNT_W-1:0]        r_total;
    logic                    r_out_valid;
    logic [CELL_W-1:0]       r_cell;
    logic [VIDX_W-1:0]       r_vidx;
    logic                    r_last;

    logic                    in_grid;
    logic                    can_emit;
    logic                    emit;
    logic                    advance;
    logic                    is_last;
    logic                    leg_end;
    logic [CELL_W-1:0]       cell_num;
    logic [COORD_W-1:0]      row_c;
    logic [COORD_W-1:0]      col_c;

    assign in_grid = !r_row[POS_W-1] && (r_row < signed'(POS_W'(r_side)))
                  && !r_col[POS_W-1] && (r_col < signed'(POS_W'(r_side)));
    assign can_emit = !r_out_valid || i_out_ready;
    assign emit     = i_cmd.walk && in_grid && can_emit;
    assign advance  = i_cmd.walk && (!in_grid || can_emit);
    assign is_last  = (r_count + CNT_W'(1)) == r_total;
    assign leg_end  = (r_leg_step + LEG_W'(1)) >= r_leg_len;
    assign cell_num = CELL_W'(r_row[2:0] * r_side) + CELL_W'(r_col[2:0]) + CELL_W'(1);
    assign row_c    = clamp_coord(i_start_row, i_side);
    assign col_c    = clamp_coord(i_start_col, i_side);

    assign o_status.done = emit && is_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_side     <= i_side;
            r_total    <= CNT_W'(i_side * i_side);
            r_row      <= signed'(POS_W'(row_c)) - POS_W'(signed'(1));
            r_col      <= signed'(POS_W'(col_c)) - POS_W'(signed'(1));
            r_heading  <= HEAD_LEFT;
            r_leg_len  <= LEG_W'(1);
            r_leg_step <= '0;
            r_count    <= '0;
        end else if (advance) begin
            r_row <= r_row + step_row(r_heading);
            r_col <= r_col + step_col(r_heading);
            if (leg_end) begin
                r_leg_step <= '0;
                r_heading  <= t_heading'(r_heading + 2'd1);
                if (r_heading[0]) begin
                    r_leg_len <= r_leg_len + LEG_W'(1);
                end
            end else begin
                r_leg_step <= r_leg_step + LEG_W'(1);
            end
            if (emit) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_cell <= cell_num;
            r_vidx <= r_count[VIDX_W-1:0];
            r_last <= is_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_number = r_cell;
    assign o_visit_index = r_vidx;
    assign o_last        = r_last;

endmodule

// ===== src/clipped_spiral_scan_generator.sv =====
`timescale 1ns / 1ps
// A start loads the walk registers; the first cell then goes through the output register.
// Throughput: one spiral position per cycle unless a full output register that is not taken
// holds it; a new start is taken only after the walk has emitted its last cell.
// A full output register that is not taken holds the walk on an in-grid cell.
// Reset is synchronous and active low; it sets the grid side to 8 and empties the output.
module clipped_spiral_scan_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // start_row [3:0], start_col [7:4]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // cell_number [6:0], visit_index [12:7], zero [15:13]
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);
    import csg_pkg::*;

    logic [COORD_W-1:0] r_grid_side;
    logic [COORD_W-1:0] side;
    t_cmd               cmd;
    t_status            status;
    logic [CELL_W-1:0]  cell_number;
    logic [VIDX_W-1:0]  visit_index;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side <= SIDE_RESET;
        end else if (i_cfg_valid) begin
            r_grid_side <= i_cfg_data;
        end
    end

    assign side = clamp_coord(r_grid_side, MAX_SIDE);

    csg_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start_valid (s_axis_tvalid),
        .i_status      (status),
        .o_start_ready (s_axis_tready),
        .o_cmd         (cmd)
    );

    csg_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_side        (side),
        .i_start_row   (s_axis_tdata[3:0]),
        .i_start_col   (s_axis_tdata[7:4]),
        .i_out_ready   (m_axis_tready),
        .o_status      (status),
        .o_out_valid   (m_axis_tvalid),
        .o_cell_number (cell_number),
        .o_visit_index (visit_index),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, visit_index, cell_number};

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the clipped spiral scan generator with a built-in spiral predictor.
module tb_top;
    import csg_pkg::*;

    localparam int unsigned CLK_PERIOD    = 10;
    localparam int unsigned RESET_CYCLES  = 12;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned RANDOM_ITEMS  = 480;
    localparam int unsigned PHASE_ITEMS   = 120;
    localparam int unsigned SEGMENT_ITEMS = 20;

    typedef enum logic [1:0] {
        IDLE_NONE = 2'd0,
        IDLE_SEND = 2'd1,
        IDLE_RECV = 2'd2,
        IDLE_BOTH = 2'd3
    } t_idle_mode;

    typedef struct {
        logic [CELL_W-1:0] cell_number;
        logic [VIDX_W-1:0] visit_index;
        logic              last;
    } t_scan_cell;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;   // start_row [3:0], start_col [7:4]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // cell_number [6:0], visit_index [12:7], zero [15:13]
    logic        m_axis_tlast;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data    = '0;

    t_scan_cell         expected_cells_q[$];
    logic [COORD_W-1:0] grid_side_reg   = SIDE_RESET;
    int unsigned        mismatch_count  = 0;
    int unsigned        quiet_cycles    = 0;
    int unsigned        send_idle_pct   = 0;
    int unsigned        recv_stall_pct  = 0;

    clipped_spiral_scan_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic int effective_side(input logic [COORD_W-1:0] side_value);
        int side;
        side = side_value;
        if (side < 1) begin
            side = 1;
        end else if (side > int'(MAX_SIDE)) begin
            side = MAX_SIDE;
        end
        return side;
    endfunction

    // Walks the clipped spiral from the start cell and queues every in-grid cell in order.
    task automatic predict_spiral(input logic [COORD_W-1:0] start_row,
                                  input logic [COORD_W-1:0] start_col);
        int         side;
        int         total;
        int         row;
        int         col;
        int         leg_len;
        int         leg_pos;
        int         count;
        t_heading   dir;
        t_scan_cell scan_entry;
        side    = effective_side(grid_side_reg);
        total   = side * side;
        row     = (start_row == 0) ? 0 : ((start_row > side) ? side - 1 : start_row - 1);
        col     = (start_col == 0) ? 0 : ((start_col > side) ? side - 1 : start_col - 1);
        leg_len = 1;
        leg_pos = 0;
        count   = 0;
        dir     = HEAD_LEFT;
        while (count < total) begin
            if (row >= 0 && row < side && col >= 0 && col < side) begin
                scan_entry.cell_number = CELL_W'(row * side + col + 1);
                scan_entry.visit_index = VIDX_W'(count);
                scan_entry.last        = (count + 1 == total);
                expected_cells_q.push_back(scan_entry);
                count++;
            end
            if (count < total) begin
                case (dir)
                    HEAD_LEFT:  col--;
                    HEAD_UP:    row--;
                    HEAD_RIGHT: col++;
                    default:    row++;
                endcase
                leg_pos++;
                if (leg_pos >= leg_len) begin
                    leg_pos = 0;
                    if (dir == HEAD_UP || dir == HEAD_DOWN) begin
                        leg_len++;
                    end
                    dir = (dir == HEAD_DOWN) ? HEAD_LEFT : t_heading'(dir + 1);
                end
            end
        end
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_result
        t_scan_cell exp_cell;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_cells_q.size() == 0) begin
                $error("unexpected result: cell_number %0d visit_index %0d last %0b",
                       m_axis_tdata[6:0], m_axis_tdata[12:7], m_axis_tlast);
                mismatch_count++;
            end else begin
                exp_cell = expected_cells_q.pop_front();
                if (m_axis_tdata[6:0] !== exp_cell.cell_number) begin
                    $error("cell_number: expected %0d, actual %0d",
                           exp_cell.cell_number, m_axis_tdata[6:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[12:7] !== exp_cell.visit_index) begin
                    $error("visit_index: expected %0d, actual %0d",
                           exp_cell.visit_index, m_axis_tdata[12:7]);
                    mismatch_count++;
                end
                if (m_axis_tlast !== exp_cell.last) begin
                    $error("last: expected %0b, actual %0b", exp_cell.last, m_axis_tlast);
                    mismatch_count++;
                end
                if (m_axis_tdata[15:13] !== 3'b000) begin
                    $error("zero padding: expected 0, actual %0d", m_axis_tdata[15:13]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("clipped_spiral_scan_generator regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic set_idling(input t_idle_mode mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 62 : ((mode == IDLE_BOTH) ? 12 : 0);
        recv_stall_pct = (mode == IDLE_RECV) ? 62 : ((mode == IDLE_BOTH) ? 12 : 0);
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_start(input logic [COORD_W-1:0] start_row,
                              input logic [COORD_W-1:0] start_col);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  <= {start_col, start_row};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_spiral(start_row, start_col);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_cells_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_grid_side(input logic [COORD_W-1:0] side_value);
        drain();
        i_cfg_data  <= side_value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        grid_side_reg = side_value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_default_side();
        set_idling(IDLE_NONE);
        send_start(4'd1, 4'd1);
        send_start(4'd8, 4'd8);
        send_start(4'd1, 4'd8);
        send_start(4'd8, 4'd1);
        send_start(4'd4, 4'd5);
        send_start(4'd0, 4'd0);
        send_start(4'd15, 4'd15);
        send_start(4'd9, 4'd0);
    endtask

    task automatic test_side_and_start_limits();
        write_grid_side(4'd1);
        send_start(4'd5, 4'd9);
        send_start(4'd1, 4'd1);
        write_grid_side(4'd0);
        send_start(4'd0, 4'd15);
        write_grid_side(4'd15);
        send_start(4'd3, 4'd4);
        send_start(4'd10, 4'd2);
        write_grid_side(4'd9);
        send_start(4'd15, 4'd0);
        write_grid_side(4'd2);
        send_start(4'd2, 4'd1);
        send_start(4'd1, 4'd2);
        write_grid_side(4'd5);
        send_start(4'd3, 4'd3);
        send_start(4'd5, 4'd1);
        write_grid_side(4'd3);
        send_start(4'd2, 4'd2);
    endtask

    function automatic logic [COORD_W-1:0] pick_start(input int side);
        if ($urandom_range(4) == 0) begin
            return COORD_W'($urandom_range(15));
        end
        return COORD_W'($urandom_range(side, 1));
    endfunction

    task automatic test_random_scan();
        t_idle_mode phase_mode;
        int         side;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            phase_mode = t_idle_mode'((i / PHASE_ITEMS) % 4);
            if (i % SEGMENT_ITEMS == 0) begin
                write_grid_side(COORD_W'($urandom_range(15)));
                set_idling(($urandom_range(3) == 0) ? IDLE_NONE : phase_mode);
            end else if ($urandom_range(39) == 0) begin
                drain();
            end
            side = effective_side(grid_side_reg);
            send_start(pick_start(side), pick_start(side));
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_default_side();
        test_side_and_start_limits();
        test_random_scan();
        set_idling(IDLE_NONE);
        drain();
        if (mismatch_count == 0) begin
            $display("clipped_spiral_scan_generator regression: pass");
        end else begin
            $display("clipped_spiral_scan_generator regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/csg_pkg.sv
src/csg_ctrl.sv
src/csg_datapath.sv
src/clipped_spiral_scan_generator.sv
tb/sv/tb_top.sv
